// File: src/pfro_pkg.sv
// shared types and constants for the page frame store raster block
package pfro_pkg;

    typedef enum logic [2:0] {
        OP_CLEAR = 3'd0,
        OP_PIXEL = 3'd1,
        OP_FILL  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_FLUSH = 3'd5
    } opcode_t;

    localparam logic [2:0] MODE_OR        = 3'd0;
    localparam logic [2:0] MODE_ANDNOT    = 3'd1;
    localparam logic [2:0] MODE_XOR       = 3'd2;
    localparam logic [2:0] MODE_KEEP      = 3'd3;
    localparam logic [2:0] MODE_OVERWRITE = 3'd4;

    localparam logic [7:0] FULL_MASK = 8'hff;
    localparam logic [7:0] ONE_BIT   = 8'b00000001;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP_RD,
        ST_SWEEP_WR,
        ST_READ,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch the incoming transaction
        logic clr_sweep;  // clear walk writes zero
        logic mem_rd;     // issue read at current address
        logic mem_wr;     // write painted byte at current address
        logic step;       // advance column/page
        logic span_upd;   // update dirty span for current address
        logic flush;      // flush span of page
        logic clear_spans;
        logic out_load;   // capture result
        logic out_clear;  // output register taken
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic oor;        // transaction dropped
        logic last;       // current address is last of the walk
        logic out_full;
        logic init_busy;  // zeroing pass after reset still running
    } stat_t;

    function automatic logic [7:0] paint(input logic [7:0] cur, input logic [7:0] din,
                                         input logic [2:0] mode);
        logic [7:0] r;
        case (mode)
            MODE_ANDNOT:    r = cur & ~din;
            MODE_XOR:       r = cur ^ din;
            MODE_KEEP:      r = cur;
            MODE_OVERWRITE: r = din;
            default:        r = cur | din;
        endcase
        return r;
    endfunction

endpackage

// File: src/pfro_ctrl.sv
// controller state machine sequencing memory walks
module pfro_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [2:0]        opcode,
    input  pfro_pkg::stat_t   stat,
    input  logic              out_taken,
    output logic              in_stall,
    output pfro_pkg::ctrl_t   ctrl
);
    pfro_pkg::state_t state_reg, state_next;
    logic [2:0] op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfro_pkg::ST_IDLE;
            op_reg    <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign in_stall = (state_reg != pfro_pkg::ST_IDLE) || stat.init_busy
                      || (stat.out_full && !out_taken);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            pfro_pkg::ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    op_next = opcode;
                    state_next = pfro_pkg::ST_SWEEP_RD;
                end
            end
            pfro_pkg::ST_SWEEP_RD:
            begin
                if (stat.oor || op_reg == pfro_pkg::OP_FLUSH || op_reg > pfro_pkg::OP_FLUSH)
                    state_next = pfro_pkg::ST_DONE;
                else if (op_reg == pfro_pkg::OP_READ)
                    state_next = pfro_pkg::ST_READ;
                else
                    state_next = pfro_pkg::ST_SWEEP_WR;
            end
            pfro_pkg::ST_SWEEP_WR:
                state_next = stat.last ? pfro_pkg::ST_DONE : pfro_pkg::ST_SWEEP_RD;
            pfro_pkg::ST_READ:
                state_next = pfro_pkg::ST_DONE;
            pfro_pkg::ST_DONE:
                state_next = pfro_pkg::ST_IDLE;
            default:
                state_next = pfro_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        ctrl.out_clear = out_taken;
        case (state_reg)
            pfro_pkg::ST_IDLE:
                ctrl.load = in_valid && !in_stall;
            pfro_pkg::ST_SWEEP_RD:
            begin
                ctrl.mem_rd = !stat.oor;
                ctrl.flush = !stat.oor && op_reg == pfro_pkg::OP_FLUSH;
            end
            pfro_pkg::ST_SWEEP_WR:
            begin
                ctrl.mem_wr    = 1'b1;
                ctrl.clr_sweep = op_reg == pfro_pkg::OP_CLEAR;
                ctrl.span_upd  = op_reg != pfro_pkg::OP_CLEAR;
                ctrl.clear_spans = op_reg == pfro_pkg::OP_CLEAR && stat.last;
                ctrl.step      = 1'b1;
            end
            pfro_pkg::ST_DONE:
                ctrl.out_load = 1'b1;
            default:
                ctrl.load = 1'b0;
        endcase
    end
endmodule

// File: src/pfro_dp.sv
// datapath: frame memory, dirty spans, address walk and result register
module pfro_dp #(
    parameter int WIDTH = 128,
    parameter int PAGES = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  pfro_pkg::ctrl_t ctrl,
    input  logic [2:0]      opcode,
    input  logic [7:0]      x_start,
    input  logic [7:0]      y_start,
    input  logic [7:0]      x_end,
    input  logic [7:0]      y_end,
    input  logic [7:0]      page_index,
    input  logic [2:0]      paint_mode,
    input  logic [7:0]      byte_value,
    output pfro_pkg::stat_t stat,
    output logic            out_valid,
    output logic [7:0]      read_value,
    output logic [6:0]      span_start,
    output logic [6:0]      span_end,
    output logic            span_valid,
    output logic            out_of_range
);
    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int DEPTH = PAGES * WIDTH;
    localparam int AW = $clog2(DEPTH);
    localparam logic [CW-1:0] CMAX = CW'(WIDTH - 1);
    localparam logic [PW-1:0] PMAX = PW'(PAGES - 1);
    localparam logic [8:0] ROWS = 9'(PAGES * 8);
    localparam logic [AW:0] DEPTH_CNT = (AW + 1)'(DEPTH);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    logic [2:0] op_reg;
    logic [2:0] mode_reg;
    logic [7:0] val_reg;
    logic [7:0] ys_reg, ye_reg;
    logic [CW-1:0] col_reg, col_lo_reg, col_hi_reg;
    logic [PW-1:0] page_reg, page_hi_reg;
    logic oor_reg;
    logic [6:0] dlow_reg [8];
    logic [6:0] dhigh_reg [8];
    logic [AW:0] init_reg;
    logic init_busy;

    logic [7:0] ye_clip;
    logic [7:0] xe_clip;
    logic in_oor;

    always_comb
    begin
        xe_clip = (x_end > 8'(WIDTH - 1)) ? 8'(WIDTH - 1) : x_end;
        ye_clip = ({1'b0, y_end} > ROWS - 9'd1) ? 8'(ROWS - 9'd1) : y_end;
        case (opcode)
            pfro_pkg::OP_CLEAR: in_oor = 1'b0;
            pfro_pkg::OP_PIXEL:
                in_oor = {1'b0, x_start} >= 9'(WIDTH) || {1'b0, y_start} >= ROWS;
            pfro_pkg::OP_FILL:
                in_oor = {1'b0, x_start} >= 9'(WIDTH) || {1'b0, y_start} >= ROWS
                         || x_end < x_start || y_end < y_start;
            pfro_pkg::OP_WRITE, pfro_pkg::OP_READ:
                in_oor = {1'b0, page_index} >= 9'(PAGES) || {1'b0, x_start} >= 9'(WIDTH);
            pfro_pkg::OP_FLUSH:
                in_oor = {1'b0, page_index} >= 9'(PAGES);
            default: in_oor = 1'b1;
        endcase
    end

    // load and walk over columns, then pages
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            op_reg   <= opcode;
            mode_reg <= paint_mode;
            val_reg  <= byte_value;
            ys_reg   <= y_start;
            ye_reg   <= (opcode == pfro_pkg::OP_PIXEL) ? y_start : ye_clip;
            oor_reg  <= in_oor;
            case (opcode)
                pfro_pkg::OP_CLEAR:
                begin
                    col_reg <= '0; col_lo_reg <= '0; col_hi_reg <= CMAX;
                    page_reg <= '0; page_hi_reg <= PMAX;
                end
                pfro_pkg::OP_PIXEL:
                begin
                    col_reg <= CW'(x_start); col_lo_reg <= CW'(x_start);
                    col_hi_reg <= CW'(x_start);
                    page_reg <= PW'(y_start[7:3]);
                    page_hi_reg <= PW'(y_start[7:3]);
                end
                pfro_pkg::OP_FILL:
                begin
                    col_reg <= CW'(x_start); col_lo_reg <= CW'(x_start);
                    col_hi_reg <= CW'(xe_clip);
                    page_reg <= PW'(y_start[7:3]);
                    page_hi_reg <= PW'(ye_clip[7:3]);
                end
                default:
                begin
                    col_reg <= CW'(x_start); col_lo_reg <= CW'(x_start);
                    col_hi_reg <= CW'(x_start);
                    page_reg <= PW'(page_index);
                    page_hi_reg <= PW'(page_index);
                end
            endcase
        end
        else if (ctrl.step)
        begin
            if (col_reg == col_hi_reg)
            begin
                col_reg  <= col_lo_reg;
                page_reg <= page_reg + PW'(1);
            end
            else
                col_reg <= col_reg + CW'(1);
        end
    end

    logic [AW-1:0] addr;
    logic [7:0] mask, pmask;
    assign addr = AW'(page_reg) * AW'(WIDTH) + AW'(col_reg);

    always_comb
    begin
        pmask = pfro_pkg::FULL_MASK;
        if (8'(page_reg) == 8'(ys_reg[7:3])) pmask = pmask & (pfro_pkg::FULL_MASK << ys_reg[2:0]);
        if (8'(page_reg) == 8'(ye_reg[7:3]))
            pmask = pmask & (pfro_pkg::FULL_MASK >> (3'd7 - ye_reg[2:0]));
        case (op_reg)
            pfro_pkg::OP_PIXEL: mask = pfro_pkg::ONE_BIT << ys_reg[2:0];
            pfro_pkg::OP_FILL:  mask = pmask;
            default:            mask = val_reg;
        endcase
    end

    // zeroing pass over the frame memory after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            init_reg <= '0;
        else if (init_busy)
            init_reg <= init_reg + (AW + 1)'(1);
    end

    assign init_busy = init_reg < DEPTH_CNT;

    always_ff @(posedge clk)
    begin
        if (ctrl.mem_rd)
            rd_data_reg <= mem[addr];
        if (init_busy)
            mem[init_reg[AW-1:0]] <= 8'd0;
        else if (ctrl.mem_wr)
            mem[addr] <= ctrl.clr_sweep ? 8'd0 : pfro_pkg::paint(rd_data_reg, mask, mode_reg);
    end

    assign stat.last = (col_reg == col_hi_reg) && (page_reg == page_hi_reg);
    assign stat.oor  = oor_reg;
    assign stat.init_busy = init_busy;

    logic [6:0] col7;
    logic [2:0] pg3;
    assign col7 = 7'(col_reg);
    assign pg3  = 3'(page_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                dlow_reg[i]  <= '0;
                dhigh_reg[i] <= '0;
            end
        end
        else if (ctrl.clear_spans)
        begin
            for (int i = 0; i < 8; i++)
            begin
                dlow_reg[i]  <= '0;
                dhigh_reg[i] <= 7'(WIDTH - 1);
            end
        end
        else if (ctrl.span_upd)
        begin
            if (col7 < dlow_reg[pg3])  dlow_reg[pg3]  <= col7;
            if (col7 > dhigh_reg[pg3]) dhigh_reg[pg3] <= col7;
        end
        else if (ctrl.flush)
        begin
            dlow_reg[pg3]  <= 7'(WIDTH - 1);
            dhigh_reg[pg3] <= '0;
        end
    end

    // result register; span captured before flush takes effect
    logic [6:0] fl_lo_reg, fl_hi_reg;
    always_ff @(posedge clk)
    begin
        if (ctrl.flush)
        begin
            fl_lo_reg <= dlow_reg[pg3];
            fl_hi_reg <= dhigh_reg[pg3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (ctrl.out_load)
            out_valid <= 1'b1;
        else if (ctrl.out_clear)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_of_range <= oor_reg;
            read_value   <= (!oor_reg && op_reg == pfro_pkg::OP_READ) ? rd_data_reg : 8'd0;
            if (!oor_reg && op_reg == pfro_pkg::OP_FLUSH)
            begin
                span_start <= fl_lo_reg;
                span_end   <= fl_hi_reg;
                span_valid <= fl_lo_reg <= fl_hi_reg;
            end
            else
            begin
                span_start <= '0;
                span_end   <= '0;
                span_valid <= 1'b0;
            end
        end
    end

    assign stat.out_full = out_valid;
endmodule

// File: src/page_framebuffer_raster_ops.sv
// Monochrome page frame store (PAGES x WIDTH bytes, bit 0 = top row of page) with
// pixel, rectangle fill, byte write/read, clear and per-page dirty span flush. One
// transaction in gives one result out. A painting transaction reads then writes each
// byte it touches (read then write on the single frame memory port), then loads its
// result; the next transaction is taken once the controller is back in idle. A read
// reads its byte and then loads its result; a flush or a dropped transaction loads
// its result straight after the first walk state. A stalled result holds off the next
// transaction. After reset a zeroing pass writes PAGES*WIDTH bytes of the frame
// memory, one per cycle, with in_stall held high until it is done.
module page_framebuffer_raster_ops #(
    parameter int WIDTH = 128,
    parameter int PAGES = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] opcode,
    input  logic [7:0] x_start,
    input  logic [7:0] y_start,
    input  logic [7:0] x_end,
    input  logic [7:0] y_end,
    input  logic [7:0] page_index,
    input  logic [2:0] paint_mode,
    input  logic [7:0] byte_value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_value,
    output logic [6:0] span_start,
    output logic [6:0] span_end,
    output logic       span_valid,
    output logic       out_of_range
);
    pfro_pkg::ctrl_t ctrl;
    pfro_pkg::stat_t stat;
    logic out_taken;

    assign out_taken = out_valid && !out_stall;

    pfro_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .opcode(opcode),
        .stat(stat), .out_taken(out_taken), .in_stall(in_stall), .ctrl(ctrl)
    );

    pfro_dp #(.WIDTH(WIDTH), .PAGES(PAGES)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .opcode(opcode),
        .x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
        .page_index(page_index), .paint_mode(paint_mode), .byte_value(byte_value),
        .stat(stat), .out_valid(out_valid), .read_value(read_value),
        .span_start(span_start), .span_end(span_end), .span_valid(span_valid),
        .out_of_range(out_of_range)
    );

    a_no_double_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> !ctrl.load) else $error("back to back load");
    a_span_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> !span_valid) else $error("span on dropped item");
    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |-> !(out_valid && out_stall)) else $error("result overwritten");
endmodule

// File: tb/testbench.sv
// self-checking testbench for the page frame store raster block
`timescale 1ns / 1ps

module testbench;

    localparam int WIDTH = 128;
    localparam int PAGES = 8;
    localparam int ROWS  = PAGES * 8;
    localparam logic [2:0] OP_BAD6 = 3'd6;
    localparam logic [2:0] OP_BAD7 = 3'd7;

    typedef struct {
        logic [7:0] read_value;
        logic [6:0] span_start;
        logic [6:0] span_end;
        logic       span_valid;
        logic       out_of_range;
    } raster_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] opcode;
    logic [7:0] x_start;
    logic [7:0] y_start;
    logic [7:0] x_end;
    logic [7:0] y_end;
    logic [7:0] page_index;
    logic [2:0] paint_mode;
    logic [7:0] byte_value;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] read_value;
    logic [6:0] span_start;
    logic [6:0] span_end;
    logic       span_valid;
    logic       out_of_range;

    // predictor state
    logic [7:0] pix_mem [PAGES*WIDTH];
    logic [6:0] span_lo [8];
    logic [6:0] span_hi [8];

    raster_result_t pending_results[$];
    int error_count;
    int burst_left;

    page_framebuffer_raster_ops #(.WIDTH(WIDTH), .PAGES(PAGES)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .x_start(x_start), .y_start(y_start),
        .x_end(x_end), .y_end(y_end), .page_index(page_index),
        .paint_mode(paint_mode), .byte_value(byte_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .read_value(read_value), .span_start(span_start), .span_end(span_end),
        .span_valid(span_valid), .out_of_range(out_of_range)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [7:0] blend(input logic [7:0] cur, input logic [7:0] din,
                                         input logic [2:0] mode);
        case (mode)
            pfro_pkg::MODE_ANDNOT:    return cur & ~din;
            pfro_pkg::MODE_XOR:       return cur ^ din;
            pfro_pkg::MODE_KEEP:      return cur;
            pfro_pkg::MODE_OVERWRITE: return din;
            default:                  return cur | din;
        endcase
    endfunction

    // a painted byte widens the page span even in keep mode
    task automatic draw_byte(input int pg, input int col, input logic [7:0] data,
                             input logic [2:0] mode);
        pix_mem[pg*WIDTH + col] = blend(pix_mem[pg*WIDTH + col], data, mode);
        if (col < span_lo[pg]) span_lo[pg] = col[6:0];
        if (col > span_hi[pg]) span_hi[pg] = col[6:0];
    endtask

    task automatic predict_raster(input logic [2:0] op, input int xs, input int ys,
                                  input int xe, input int ye, input int pg,
                                  input logic [2:0] mode, input logic [7:0] val);
        raster_result_t r;
        logic [7:0] mask;
        int ps;
        int pe;
        r = '{default: '0};
        case (op)
            pfro_pkg::OP_CLEAR:
            begin
                foreach (pix_mem[i]) pix_mem[i] = '0;
                for (int p = 0; p < PAGES; p++)
                begin
                    span_lo[p] = '0;
                    span_hi[p] = 7'(WIDTH - 1);
                end
            end
            pfro_pkg::OP_PIXEL:
                if (xs >= WIDTH || ys >= ROWS) r.out_of_range = 1'b1;
                else draw_byte(ys >> 3, xs, pfro_pkg::ONE_BIT << (ys & 7), mode);
            pfro_pkg::OP_FILL:
                if (xs >= WIDTH || ys >= ROWS || xe < xs || ye < ys) r.out_of_range = 1'b1;
                else
                begin
                    if (xe > WIDTH - 1) xe = WIDTH - 1;
                    if (ye > ROWS - 1) ye = ROWS - 1;
                    ps = ys >> 3;
                    pe = ye >> 3;
                    for (int p = ps; p <= pe; p++)
                    begin
                        mask = pfro_pkg::FULL_MASK;
                        if (p == ps) mask = mask & (pfro_pkg::FULL_MASK << (ys & 7));
                        if (p == pe) mask = mask & (pfro_pkg::FULL_MASK >> (7 - (ye & 7)));
                        for (int c = xs; c <= xe; c++) draw_byte(p, c, mask, mode);
                    end
                end
            pfro_pkg::OP_WRITE:
                if (pg >= PAGES || xs >= WIDTH) r.out_of_range = 1'b1;
                else draw_byte(pg, xs, val, mode);
            pfro_pkg::OP_READ:
                if (pg >= PAGES || xs >= WIDTH) r.out_of_range = 1'b1;
                else r.read_value = pix_mem[pg*WIDTH + xs];
            pfro_pkg::OP_FLUSH:
                if (pg >= PAGES) r.out_of_range = 1'b1;
                else
                begin
                    r.span_start = span_lo[pg];
                    r.span_end   = span_hi[pg];
                    r.span_valid = span_lo[pg] <= span_hi[pg];
                    span_lo[pg]  = 7'(WIDTH - 1);
                    span_hi[pg]  = '0;
                end
            default: r.out_of_range = 1'b1;
        endcase
        pending_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // one transaction; valid stays high across a burst
    task automatic send_op(input logic [2:0] op, input int xs, input int ys, input int xe,
                           input int ye, input int pg, input logic [2:0] mode,
                           input logic [7:0] val);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        x_start    <= xs[7:0];
        y_start    <= ys[7:0];
        x_end      <= xe[7:0];
        y_end      <= ye[7:0];
        page_index <= pg[7:0];
        paint_mode <= mode;
        byte_value <= val;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_raster(op, xs & 8'hff, ys & 8'hff, xe & 8'hff, ye & 8'hff, pg & 8'hff,
                       mode, val);
        burst_left--;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // receiver stall pattern: phases of none, light, and heavy stall
    int stall_phase;
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_phase <= 0;
            stall_left  <= 0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_phase <= $urandom_range(0, 2);
                stall_left  <= $urandom_range(20, 200);
            end
            else stall_left <= stall_left - 1;
            case (stall_phase)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        raster_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected result transaction at %0t", $time);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_value !== want.read_value)
                    report_mismatch("read_value", read_value, want.read_value);
                if (span_start !== want.span_start)
                    report_mismatch("span_start", span_start, want.span_start);
                if (span_end !== want.span_end)
                    report_mismatch("span_end", span_end, want.span_end);
                if (span_valid !== want.span_valid)
                    report_mismatch("span_valid", span_valid, want.span_valid);
                if (out_of_range !== want.out_of_range)
                    report_mismatch("out_of_range", out_of_range, want.out_of_range);
            end
        end
    end

    // store and spans after reset, before any drawing
    task automatic test_reset_spans();
        send_op(pfro_pkg::OP_READ, 17, 0, 0, 0, 2, pfro_pkg::MODE_OR, 8'h00);
        for (int p = 0; p < PAGES; p++)
            send_op(pfro_pkg::OP_FLUSH, 0, 0, 0, 0, p, pfro_pkg::MODE_OR, 8'h00);
    endtask

    task automatic test_directed();
        send_op(pfro_pkg::OP_CLEAR, 0, 0, 0, 0, 0, pfro_pkg::MODE_OR, 8'h00);
        send_op(pfro_pkg::OP_FLUSH, 0, 0, 0, 0, 3, pfro_pkg::MODE_OR, 8'h00);
        send_op(pfro_pkg::OP_PIXEL, 0, 0, 0, 0, 0, pfro_pkg::MODE_OR, 8'h00);
        send_op(pfro_pkg::OP_PIXEL, WIDTH - 1, ROWS - 1, 0, 0, 0, pfro_pkg::MODE_XOR, 8'h00);
        send_op(pfro_pkg::OP_PIXEL, WIDTH, 5, 0, 0, 0, pfro_pkg::MODE_OR, 8'h00);
        send_op(pfro_pkg::OP_PIXEL, 3, 255, 0, 0, 0, pfro_pkg::MODE_OR, 8'h00);
        send_op(pfro_pkg::OP_FILL, 0, 0, 255, 255, 0, pfro_pkg::MODE_OVERWRITE, 8'h00);
        send_op(pfro_pkg::OP_FILL, 10, 3, 20, 12, 0, pfro_pkg::MODE_ANDNOT, 8'h00);
        send_op(pfro_pkg::OP_FILL, 20, 3, 19, 12, 0, pfro_pkg::MODE_OR, 8'h00);
        send_op(pfro_pkg::OP_FILL, 5, 9, 8, 8, 0, pfro_pkg::MODE_OR, 8'h00);
        send_op(pfro_pkg::OP_FILL, 30, 1, 31, 6, 0, pfro_pkg::MODE_KEEP, 8'h00);
        send_op(pfro_pkg::OP_WRITE, WIDTH - 1, 0, 0, 0, PAGES - 1, pfro_pkg::MODE_OVERWRITE,
                8'hff);
        send_op(pfro_pkg::OP_WRITE, 0, 0, 0, 0, 0, pfro_pkg::MODE_XOR, 8'ha5);
        send_op(pfro_pkg::OP_WRITE, 0, 0, 0, 0, PAGES, pfro_pkg::MODE_OR, 8'h5a);
        send_op(pfro_pkg::OP_WRITE, 1, 0, 0, 0, 0, 3'd5, 8'h81);
        send_op(pfro_pkg::OP_WRITE, 2, 0, 0, 0, 0, 3'd7, 8'h7e);
        send_op(pfro_pkg::OP_READ, 0, 0, 0, 0, 0, pfro_pkg::MODE_OR, 8'h00);
        send_op(pfro_pkg::OP_READ, 1, 0, 0, 0, 0, pfro_pkg::MODE_OR, 8'h00);
        send_op(pfro_pkg::OP_READ, 15, 0, 0, 0, 1, pfro_pkg::MODE_OR, 8'h00);
        send_op(pfro_pkg::OP_READ, 255, 0, 0, 0, 255, pfro_pkg::MODE_OR, 8'h00);
        send_op(pfro_pkg::OP_FLUSH, 0, 0, 0, 0, 0, pfro_pkg::MODE_OR, 8'h00);
        send_op(pfro_pkg::OP_FLUSH, 0, 0, 0, 0, 0, pfro_pkg::MODE_OR, 8'h00);
        send_op(pfro_pkg::OP_FLUSH, 0, 0, 0, 0, 255, pfro_pkg::MODE_OR, 8'h00);
        send_op(OP_BAD6, 1, 1, 1, 1, 1, pfro_pkg::MODE_OR, 8'h01);
        send_op(OP_BAD7, 1, 1, 1, 1, 1, pfro_pkg::MODE_OR, 8'h01);
    endtask

    task automatic test_random(input int count);
        int sel;
        int xs;
        int ys;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 99);
            xs  = $urandom_range(0, WIDTH - 1);
            ys  = $urandom_range(0, ROWS - 1);
            if (sel < 2)
                send_op(pfro_pkg::OP_CLEAR, $urandom_range(0, 255), 0, 0, 0, 0,
                        pfro_pkg::MODE_OR, 8'h00);
            else if (sel < 27)
                send_op(pfro_pkg::OP_PIXEL, xs, ys, 0, 0, 0, 3'($urandom_range(0, 7)), 8'h00);
            else if (sel < 45)
                send_op(pfro_pkg::OP_FILL, xs, ys, xs + $urandom_range(0, 12),
                        ys + $urandom_range(0, 14), 0, 3'($urandom_range(0, 7)), 8'h00);
            else if (sel < 47)
                send_op(pfro_pkg::OP_FILL, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255), 0,
                        3'($urandom_range(0, 7)), 8'h00);
            else if (sel < 67)
                send_op(pfro_pkg::OP_WRITE, xs, 0, 0, 0, $urandom_range(0, PAGES - 1),
                        3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            else if (sel < 85)
                send_op(pfro_pkg::OP_READ, xs, 0, 0, 0, $urandom_range(0, PAGES - 1),
                        pfro_pkg::MODE_OR, 8'h00);
            else if (sel < 95)
                send_op(pfro_pkg::OP_FLUSH, 0, 0, 0, 0, $urandom_range(0, PAGES - 1),
                        pfro_pkg::MODE_OR, 8'h00);
            else
                // noise: any opcode but clear, every field at full width
                send_op(3'($urandom_range(1, 7)), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        error_count = 0;
        burst_left  = 0;
        foreach (pix_mem[i]) pix_mem[i] = '0;
        foreach (span_lo[i])
        begin
            span_lo[i] = '0;
            span_hi[i] = '0;
        end
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = pfro_pkg::OP_CLEAR;
        x_start    = '0;
        y_start    = '0;
        x_end      = '0;
        y_end      = '0;
        page_index = '0;
        paint_mode = pfro_pkg::MODE_OR;
        byte_value = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_spans();
        test_directed();
        test_random(1800);
        drain_results();
        repeat (50) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
src/pfro_pkg.sv
src/pfro_ctrl.sv
src/pfro_dp.sv
src/page_framebuffer_raster_ops.sv
tb/testbench.sv
